// ===== hdl/next_fit_slot_allocator_top_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the next-fit slot allocator
// Shorthand for clocked implication checks, disabled while reset is held.
// ----------------------------------------------------------------------------
`ifndef NEXT_FIT_SLOT_ALLOCATOR_TOP_ASSERT_SVH
`define NEXT_FIT_SLOT_ALLOCATOR_TOP_ASSERT_SVH

// Same-cycle implication: when ante holds, cons holds in that cycle.
`define NFSA_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication: when ante holds, cons holds in the cycle after.
`define NFSA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/nfsa_pkg.sv =====
// ----------------------------------------------------------------------------
// nfsa_pkg
// Types and constants shared by the next-fit slot allocator modules.
// ----------------------------------------------------------------------------
package nfsa_pkg;

    // Width of the next-fit pointer; it can hold the slot count itself.
    localparam int PTR_W = 9;
    // Width of a slot number on the ports.
    localparam int IDX_W = 8;

    // Command codes carried on the input word.
    typedef enum logic [1:0] {
        CMD_ALLOC       = 2'd0,
        CMD_RELEASE     = 2'd1,
        CMD_RELEASE_ALL = 2'd2,
        CMD_QUERY       = 2'd3
    } cmd_t;

    // Status codes carried on the result word.
    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } status_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_LOOK,
        S_FIN
    } state_t;

    // One result word handed from the sequencer to the output stage.
    typedef struct packed {
        status_t            status;
        logic [IDX_W-1:0]   granted_slot;
        logic               occupied;
    } res_t;

endpackage

// ===== hdl/next_fit_slot_allocator_top.sv =====
// ----------------------------------------------------------------------------
// next_fit_slot_allocator_top
// Next-fit connection slot allocator with allocate, release, release-all and
// query commands over stream channels.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake                    Payload
// s_axis    in   s_axis_tvalid/s_axis_tready  tuser: command, tdata: slot_index
// m_axis    out  m_axis_tvalid/m_axis_tready  tuser: status,
//                                             tdata: granted_slot, occupied
//
// Allocate examines the slots in turn from the next-fit pointer, at most
// SLOTS - 1 of them; one compare unit reads the map each cycle.
// One command is in work at a time; a new word is taken while the last result
// still waits in the output register.
// Reset clears the map and sets the next-fit pointer to slot 1.
// ----------------------------------------------------------------------------
`include "next_fit_slot_allocator_top_assert.svh"

module next_fit_slot_allocator_top
    import nfsa_pkg::*;
#(
    parameter int SLOTS = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    // Command stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] slot_index
    input  logic [1:0]  s_axis_tuser,   // [1:0] command
    // Result stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] granted_slot, [8] occupied, [15:9] zero
    output logic [1:0]  m_axis_tuser    // [1:0] status
);

    logic   res_valid;
    logic   res_ready;
    res_t   res;
    logic   out_vld_reg, out_vld_next;
    res_t   out_res_reg, out_res_next;

    nfsa_ctrl #(
        .SLOTS (SLOTS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (s_axis_tvalid),
        .cmd_ready (s_axis_tready),
        .cmd       (cmd_t'(s_axis_tuser)),
        .cmd_idx   (s_axis_tdata),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // Output register: it takes a new word whenever it is empty or being drained.
    assign res_ready = !out_vld_reg || m_axis_tready;

    always_comb
    begin
        out_vld_next = out_vld_reg;
        out_res_next = out_res_reg;
        if (res_valid && res_ready)
        begin
            out_vld_next = 1'b1;
            out_res_next = res;
        end
        else if (m_axis_tready)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else
        begin
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_res_reg <= out_res_next;
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tuser  = out_res_reg.status;
    assign m_axis_tdata  = {7'd0, out_res_reg.occupied, out_res_reg.granted_slot};

    // A taken command keeps the input from being ready in the cycle after.
    `NFSA_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready,
        "input taken again right after a command")
    // A full table never reports a granted slot.
    `NFSA_ASSERT_SAME(a_full_no_grant, m_axis_tvalid && (m_axis_tuser == ST_FULL),
        m_axis_tdata[7:0] == 8'd0, "granted slot on a full table")
    // A granted slot always lies within the table.
    `NFSA_ASSERT_SAME(a_grant_in_range, m_axis_tvalid,
        {1'b0, m_axis_tdata[7:0]} < 9'(SLOTS), "granted slot beyond the table")

endmodule

// ===== hdl/nfsa_ram.sv =====
// ----------------------------------------------------------------------------
// nfsa_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module nfsa_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/nfsa_ctrl.sv =====
// ----------------------------------------------------------------------------
// nfsa_ctrl
// Command sequencer: owns the occupancy map and walks it one slot a cycle
// through a single compare unit for next-fit allocation.
// ----------------------------------------------------------------------------
module nfsa_ctrl
    import nfsa_pkg::*;
#(
    parameter int SLOTS = 256
) (
    input  logic             clk,
    input  logic             rst_n,
    // Command side.
    input  logic             cmd_valid,
    output logic             cmd_ready,
    input  cmd_t             cmd,
    input  logic [IDX_W-1:0] cmd_idx,
    // Result side.
    output logic             res_valid,
    input  logic             res_ready,
    output res_t             res
);

    localparam int                 AW        = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [PTR_W-1:0]   SLOT_CNT  = PTR_W'(SLOTS);
    localparam logic [PTR_W-1:0]   LAST_SLOT = PTR_W'(SLOTS - 1);
    localparam logic [PTR_W-1:0]   FIRST_USE = PTR_W'(1);

    state_t             state_reg, state_next;
    cmd_t               cmd_reg, cmd_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [PTR_W-1:0]   ptr_reg, ptr_next;
    logic [PTR_W-1:0]   scan_reg, scan_next;
    logic [PTR_W-1:0]   stop_reg, stop_next;
    logic               wrap_reg, wrap_next;
    logic               chk_vld_reg, chk_vld_next;
    logic [AW-1:0]      chk_idx_reg, chk_idx_next;
    logic [SLOTS-1:0]   valid_reg, valid_next;
    res_t               res_reg, res_next;

    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic               ram_wdata;
    logic               ram_re;
    logic [AW-1:0]      ram_raddr;
    logic               ram_rdata;

    logic               in_range;
    logic               chk_used;
    logic               look_used;

    // The map itself; an entry counts as used only while its valid bit is set.
    nfsa_ram #(
        .WIDTH (1),
        .DEPTH (SLOTS)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign in_range  = ({1'b0, cmd_idx} < SLOT_CNT);
    assign chk_used  = valid_reg[chk_idx_reg] & ram_rdata;
    assign look_used = valid_reg[idx_reg[AW-1:0]] & ram_rdata;

    assign cmd_ready = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_FIN);
    assign res       = res_reg;

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            ptr_reg     <= FIRST_USE;
            valid_reg   <= '0;
            chk_vld_reg <= 1'b0;
            wrap_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            ptr_reg     <= ptr_next;
            valid_reg   <= valid_next;
            chk_vld_reg <= chk_vld_next;
            wrap_reg    <= wrap_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        idx_reg     <= idx_next;
        scan_reg    <= scan_next;
        stop_reg    <= stop_next;
        chk_idx_reg <= chk_idx_next;
        res_reg     <= res_next;
    end

    // Next state, map accesses and the scan step.
    always_comb
    begin
        state_next   = state_reg;
        cmd_next     = cmd_reg;
        idx_next     = idx_reg;
        ptr_next     = ptr_reg;
        scan_next    = scan_reg;
        stop_next    = stop_reg;
        wrap_next    = wrap_reg;
        chk_vld_next = chk_vld_reg;
        chk_idx_next = chk_idx_reg;
        valid_next   = valid_reg;
        res_next     = res_reg;
        ram_we       = 1'b0;
        ram_waddr    = chk_idx_reg;
        ram_wdata    = 1'b0;
        ram_re       = 1'b0;
        ram_raddr    = scan_reg[AW-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_next = cmd;
                    idx_next = cmd_idx;
                    case (cmd)
                        CMD_ALLOC:
                        begin
                            // Start at the pointer, or at slot 1 when it sits past the top.
                            chk_vld_next = 1'b0;
                            if (ptr_reg < SLOT_CNT)
                            begin
                                scan_next = ptr_reg;
                                stop_next = ptr_reg;
                                wrap_next = 1'b0;
                            end
                            else
                            begin
                                scan_next = FIRST_USE;
                                stop_next = SLOT_CNT;
                                wrap_next = 1'b1;
                            end
                            state_next = S_SCAN;
                        end
                        CMD_RELEASE_ALL:
                        begin
                            valid_next = '0;
                            res_next   = '{status: ST_DONE, granted_slot: '0, occupied: 1'b0};
                            state_next = S_FIN;
                        end
                        default:
                        begin
                            // Release and query read the slot first when it lies within the table.
                            if (in_range)
                            begin
                                ram_re     = 1'b1;
                                ram_raddr  = cmd_idx[AW-1:0];
                                state_next = S_LOOK;
                            end
                            else
                            begin
                                res_next   = '{status: ST_RANGE, granted_slot: '0,
                                               occupied: 1'b0};
                                state_next = S_FIN;
                            end
                        end
                    endcase
                end
            end

            S_LOOK:
            begin
                res_next = '{status: ST_DONE, granted_slot: '0, occupied: look_used};
                if (cmd_reg == CMD_RELEASE)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = idx_reg[AW-1:0];
                    ram_wdata = 1'b0;
                end
                state_next = S_FIN;
            end

            S_SCAN:
            begin
                if (chk_vld_reg && !chk_used)
                begin
                    // Free slot found: claim it and move the pointer past it.
                    ram_we                  = 1'b1;
                    ram_waddr               = chk_idx_reg;
                    ram_wdata               = 1'b1;
                    valid_next[chk_idx_reg] = 1'b1;
                    ptr_next                = PTR_W'(chk_idx_reg) + FIRST_USE;
                    chk_vld_next            = 1'b0;
                    res_next   = '{status: ST_DONE, granted_slot: IDX_W'(chk_idx_reg),
                                   occupied: 1'b0};
                    state_next = S_FIN;
                end
                else if (!wrap_reg || (scan_reg < stop_reg))
                begin
                    // Issue the next read while the previous one is checked.
                    ram_re       = 1'b1;
                    ram_raddr    = scan_reg[AW-1:0];
                    chk_vld_next = 1'b1;
                    chk_idx_next = scan_reg[AW-1:0];
                    if (!wrap_reg && (scan_reg == LAST_SLOT))
                    begin
                        scan_next = FIRST_USE;
                        wrap_next = 1'b1;
                    end
                    else
                    begin
                        scan_next = scan_reg + FIRST_USE;
                    end
                end
                else
                begin
                    chk_vld_next = 1'b0;
                    if (!chk_vld_reg)
                    begin
                        // Every slot checked and none free.
                        res_next   = '{status: ST_FULL, granted_slot: '0, occupied: 1'b0};
                        state_next = S_FIN;
                    end
                end
            end

            S_FIN:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
